FILE: rtl/temp_sensor_scratchpad_check_assert.svh
// Assertion macros shared by the scratchpad checker modules.
// Each macro gets a label, the clock, the active-low reset, a condition,
// a consequence and a message string.
`ifndef TEMP_SENSOR_SCRATCHPAD_CHECK_ASSERT_SVH
`define TEMP_SENSOR_SCRATCHPAD_CHECK_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TSC_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the condition.
`define TSC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
package tsc_pkg;

	// Input item kinds.
	localparam logic KIND_BUS_RESET = 1'b0;
	localparam logic KIND_SCRATCH   = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_CRC_ERROR = 2'd1;
	localparam logic [1:0] ST_NO_DEVICE = 2'd2;

	// Resolution codes from configuration byte bits 6..5.
	localparam logic [1:0] RES_9_BIT  = 2'd0;
	localparam logic [1:0] RES_10_BIT = 2'd1;
	localparam logic [1:0] RES_11_BIT = 2'd2;
	localparam logic [1:0] RES_12_BIT = 2'd3;

	// Scratchpad layout.
	localparam logic [3:0] BYTE_TEMP_LO   = 4'd0;
	localparam logic [3:0] BYTE_TEMP_HI   = 4'd1;
	localparam logic [3:0] BYTE_CONFIG    = 4'd4;
	localparam logic [3:0] BYTE_CRC       = 4'd8;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam int unsigned QUEUE_DEPTH = 2;

	// One queued result, before resolution masking.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] raw_temp;
		logic [1:0]  res_code;
	} tsc_cmd_t;

	// Reflected CRC-8 update, one byte, data least significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] crc;
		logic mix;
		crc = crc_in;
		for (int k = 0; k < 8; k++) begin
			mix = crc[0] ^ b[k];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

FILE: rtl/tsc_queue.sv
`timescale 1ns / 1ps
`include "temp_sensor_scratchpad_check_assert.svh"
module tsc_queue #(
	parameter int unsigned Width = 20,
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [Width-1:0] rd_data
);
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CntW'(Depth);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TSC_ASSERT_SAME(a_no_push_when_full, clk, arst_n, push, !full, "push into a full queue")
	`TSC_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CntW'(Depth), "queue count overrun")
	`TSC_ASSERT_NEXT(a_push_grows, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")
	`TSC_ASSERT_NEXT(a_both_hold, clk, arst_n, do_push && do_pop, count_q == $past(count_q), "count moved on push and pop")
endmodule

FILE: rtl/tsc_front.sv
`timescale 1ns / 1ps
module tsc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic              presence,
	input  logic [7:0]        data_byte,
	input  logic              q_full,
	output logic              push,
	output tsc_pkg::tsc_cmd_t cmd
);
	import tsc_pkg::*;

	logic       frame_open_q;
	logic [3:0] byte_count_q;
	logic [7:0] crc_q;
	logic [7:0] temp_lo_q;
	logic [7:0] temp_hi_q;
	logic [1:0] res_q;

	logic accept;
	logic no_device;
	logic open_frame;
	logic frame_byte;
	logic frame_end;
	logic crc_ok;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign no_device  = (kind == KIND_BUS_RESET) && !presence;
	assign open_frame = (kind == KIND_BUS_RESET) && presence;
	assign frame_byte = (kind == KIND_SCRATCH) && frame_open_q;
	assign frame_end  = frame_byte && (byte_count_q >= BYTE_CRC);
	assign crc_ok     = crc_q == data_byte;
	assign push       = accept && (no_device || frame_end);

	always_comb begin
		cmd = '0;
		priority if (no_device) begin
			cmd.status = ST_NO_DEVICE;
		end else if (crc_ok) begin
			cmd.status   = ST_VALID;
			cmd.raw_temp = {temp_hi_q, temp_lo_q};
			cmd.res_code = res_q;
		end else begin
			cmd.status = ST_CRC_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			byte_count_q <= '0;
			crc_q        <= '0;
			temp_lo_q    <= '0;
			temp_hi_q    <= '0;
			res_q        <= '0;
		end else if (accept) begin
			priority if (no_device) begin
				frame_open_q <= 1'b0;
			end else if (open_frame) begin
				frame_open_q <= 1'b1;
				byte_count_q <= '0;
				crc_q        <= '0;
			end else if (frame_end) begin
				frame_open_q <= 1'b0;
				byte_count_q <= '0;
			end else if (frame_byte) begin
				if (byte_count_q == BYTE_TEMP_LO) begin
					temp_lo_q <= data_byte;
				end
				if (byte_count_q == BYTE_TEMP_HI) begin
					temp_hi_q <= data_byte;
				end
				if (byte_count_q == BYTE_CONFIG) begin
					res_q <= data_byte[6:5];
				end
				crc_q        <= crc8_update(crc_q, data_byte);
				byte_count_q <= byte_count_q + 1'b1;
			end else begin
				// A byte outside a frame leaves every register as it is.
			end
		end
	end
endmodule

FILE: rtl/tsc_back.sv
`timescale 1ns / 1ps
`include "temp_sensor_scratchpad_check_assert.svh"
module tsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tsc_pkg::tsc_cmd_t  q_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [15:0] temperature,
	output logic [1:0]         resolution_code
);
	import tsc_pkg::*;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [15:0] temp_q;
	logic [1:0]         res_q;
	logic [15:0]        masked;

	// Clear the bits below the sensor's resolution.
	always_comb begin
		unique case (q_cmd.res_code)
			RES_9_BIT:  masked = q_cmd.raw_temp & 16'hFFF8;
			RES_10_BIT: masked = q_cmd.raw_temp & 16'hFFFC;
			RES_11_BIT: masked = q_cmd.raw_temp & 16'hFFFE;
			RES_12_BIT: masked = q_cmd.raw_temp;
			default:    masked = q_cmd.raw_temp;
		endcase
	end

	assign pop             = q_valid && (!out_valid_q || out_ready);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign temperature     = temp_q;
	assign resolution_code = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= q_cmd.status;
			temp_q   <= masked;
			res_q    <= q_cmd.res_code;
		end
	end

	`TSC_ASSERT_SAME(a_error_zeroed, clk, arst_n, out_valid_q && (status_q != ST_VALID), (temp_q == 16'sd0) && (res_q == '0), "error result carries data")
	`TSC_ASSERT_SAME(a_status_code, clk, arst_n, out_valid_q, (status_q == ST_VALID) || (status_q == ST_CRC_ERROR) || (status_q == ST_NO_DEVICE), "bad status code")
	`TSC_ASSERT_SAME(a_mask_9bit, clk, arst_n, out_valid_q && (res_q == RES_9_BIT), temp_q[2:0] == 3'd0, "9-bit result has low bits set")
	`TSC_ASSERT_NEXT(a_pop_loads, clk, arst_n, pop, out_valid_q, "popped result not shown")
endmodule

FILE: rtl/temp_sensor_scratchpad_check.sv
// Scratchpad checker for a one-wire temperature sensor.
// Input channel (in_valid/in_ready): each beat is either a bus-reset outcome
// (kind 0, presence flag) or one scratchpad byte (kind 1, data_byte). A reset
// with presence opens a nine-byte frame; bytes outside a frame are dropped.
// Output channel (out_valid/out_ready): one beat for a reset without presence
// (no device) and one beat after the ninth byte of a frame, carrying either the
// resolution-masked temperature or a CRC error with zero data.
// A result beat is registered in the queue and then in the output register before it shows.
// Throughput: one input beat per cycle while in_ready is high; the front end updates
// the CRC for a whole byte as each beat is accepted.
// Results pass through a small queue and an output register, so input beats
// keep flowing while a result waits. When the receiver stalls long enough to
// fill the queue, in_ready drops until a result is taken.
// Reset (arst_n low) closes any frame, clears the CRC and byte count, and
// empties the queue and output register. No clearing pass is needed.
`timescale 1ns / 1ps
module temp_sensor_scratchpad_check #(
	parameter int unsigned QueueDepth = tsc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic               presence,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [15:0] temperature,
	output logic [1:0]         resolution_code
);
	import tsc_pkg::*;

	// Front to queue.
	logic     push;
	logic     q_full;
	tsc_cmd_t push_cmd;

	// Queue to back.
	logic     pop;
	logic     q_valid;
	tsc_cmd_t head_cmd;

	// The front end tracks the frame, the CRC and the captured bytes, and
	// decides per beat whether a result is due.
	tsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.presence  (presence),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Pending results wait here while the receiver stalls.
	tsc_queue #(
		.Width ($bits(tsc_cmd_t)),
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (head_cmd)
	);

	// The back end applies resolution masking and holds the output beat.
	tsc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (head_cmd),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.temperature     (temperature),
		.resolution_code (resolution_code)
	);
endmodule

FILE: tb/tb_temp_sensor_scratchpad_check.sv
`timescale 1ns / 1ps
module tb_temp_sensor_scratchpad_check;
	import tsc_pkg::*;

	// Clock is 50 MHz. The run length is bounded by a plain cycle counter, sized far above
	// the slowest legal run: about 2000 input beats, each behind a random sender gap, plus
	// a few hundred result beats that can sit behind receiver phases that take a beat only
	// one cycle in twenty.
	localparam int unsigned CLK_HALF    = 10;
	localparam int unsigned ITEM_TARGET = 1800;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One decoded temperature reading as it should leave the block.
	typedef struct {
		logic [1:0]         status;
		logic signed [15:0] temperature;
		logic [1:0]         res;
	} reading_t;

	// A full scratchpad image: eight data bytes and the CRC byte.
	typedef logic [7:0] pad_t [9];

	// The scoreboard keeps its own copy of the decoder state. Every accepted input beat
	// moves that state the way the block should, and any reading that the beat produces
	// is queued. Every result beat is then checked against the oldest queued reading.
	class scratchpad_scoreboard;
		bit         frame_open;
		logic [3:0] byte_idx;
		logic [7:0] crc_acc;
		logic [7:0] temp_lo;
		logic [7:0] temp_hi;
		logic [1:0] res_bits;
		reading_t   expected_q[$];
		int         errors;
		int         n_good;
		int         n_crc_bad;
		int         n_no_dev;

		function new();
			frame_open = 1'b0;
			byte_idx   = '0;
			crc_acc    = '0;
			temp_lo    = '0;
			temp_hi    = '0;
			res_bits   = '0;
			errors     = 0;
			n_good     = 0;
			n_crc_bad  = 0;
			n_no_dev   = 0;
		endfunction

		// Reflected CRC-8, polynomial 0x8C, one byte, least significant bit first.
		function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
			logic [7:0] c;
			int         k;
			c = crc;
			for (k = 0; k < 8; k++) begin
				if (c[0] ^ b[k]) begin
					c = (c >> 1) ^ CRC_POLY;
				end else begin
					c = c >> 1;
				end
			end
			return c;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_beat(logic k, logic p, logic [7:0] d);
			reading_t    r;
			logic [15:0] raw;
			r.status      = ST_NO_DEVICE;
			r.temperature = '0;
			r.res         = '0;
			if (k == KIND_BUS_RESET) begin
				if (!p) begin
					// No device answered: close the frame, leave the CRC alone.
					frame_open = 1'b0;
					expected_q.push_back(r);
				end else begin
					frame_open = 1'b1;
					byte_idx   = '0;
					crc_acc    = '0;
				end
			end else if (frame_open) begin
				if (byte_idx >= BYTE_CRC) begin
					frame_open = 1'b0;
					byte_idx   = '0;
					if (crc_acc == d) begin
						raw = {temp_hi, temp_lo};
						case (res_bits)
							RES_9_BIT:  raw[2:0] = '0;
							RES_10_BIT: raw[1:0] = '0;
							RES_11_BIT: raw[0]   = 1'b0;
							default: ;
						endcase
						r.status      = ST_VALID;
						r.temperature = raw;
						r.res         = res_bits;
					end else begin
						r.status = ST_CRC_ERROR;
					end
					expected_q.push_back(r);
				end else begin
					case (byte_idx)
						BYTE_TEMP_LO: temp_lo  = d;
						BYTE_TEMP_HI: temp_hi  = d;
						BYTE_CONFIG:  res_bits = d[6:5];
						default: ;
					endcase
					crc_acc  = crc_next(crc_acc, d);
					byte_idx = byte_idx + 1'b1;
				end
			end
		endfunction

		function void check_result(logic [1:0] st, logic signed [15:0] t, logic [1:0] rc);
			reading_t r;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: status=%0d temperature=%0d res=%0d",
					st, t, rc);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				errors++;
			end
			if (t !== r.temperature) begin
				$error("temperature: expected %0d, actual %0d", r.temperature, t);
				errors++;
			end
			if (rc !== r.res) begin
				$error("resolution_code: expected %0d, actual %0d", r.res, rc);
				errors++;
			end
			case (r.status)
				ST_VALID:     n_good++;
				ST_CRC_ERROR: n_crc_bad++;
				default:      n_no_dev++;
			endcase
		endfunction
	endclass

	// Every input of the block holds a known value from time zero on.
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               kind      = 1'b0;
	logic               presence  = 1'b0;
	logic [7:0]         data_byte = '0;
	logic               out_ready = 1'b0;
	logic               in_ready;
	logic               out_valid;
	logic [1:0]         status;
	logic signed [15:0] temperature;
	logic [1:0]         resolution_code;

	scratchpad_scoreboard sb = new();

	int unsigned cycle_count     = 0;
	int unsigned in_stall_cycles = 0;
	int unsigned beats_sent      = 0;
	int unsigned ignored_beats   = 0;
	int unsigned burst_left      = 0;
	bit          hold_req        = 1'b0;
	int unsigned hold_count      = 0;

	temp_sensor_scratchpad_check u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.presence        (presence),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.temperature     (temperature),
		.resolution_code (resolution_code)
	);

	always #(CLK_HALF) clk = ~clk;

	// Watchdog. A hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d readings outstanding.",
				cycle_count, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Output monitor. Signals are read at the edge before any update scheduled for it
	// takes effect, so this sees the same handshake that the block sees.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(status, temperature, resolution_code);
		end
		if (arst_n && in_valid && !in_ready) begin
			in_stall_cycles++;
		end
	end

	// Receiver. It takes beats at a rate that changes from phase to phase, from every cycle
	// down to one in twenty. On request it holds off completely for a fixed number of
	// cycles, which lets the result queue fill and pushes back on the input side.
	initial begin : receiver
		int unsigned ready_pct;
		int unsigned phase_left;
		ready_pct  = 100;
		phase_left = 0;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				hold_count++;
			end else begin
				if (phase_left == 0) begin
					case ($urandom_range(0, 4))
						0, 1:    ready_pct = 100;
						2:       ready_pct = 70;
						3:       ready_pct = 35;
						default: ready_pct = 5;
					endcase
					phase_left = $urandom_range(20, 120);
				end
				phase_left--;
				out_ready <= ($urandom_range(0, 99) < ready_pct);
				@(posedge clk);
			end
		end
	end

	// Offers one input beat and returns at the edge where it is accepted. Beats come in
	// bursts of random length; between bursts valid drops for a random gap, or not at all
	// when the gap comes out as zero, so that long back-to-back stretches occur as well.
	task automatic send_beat(input logic k, input logic p, input logic [7:0] d);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid  <= 1'b1;
		kind      <= k;
		presence  <= p;
		data_byte <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(k, p, d);
		beats_sent++;
	endtask

	// Lowers valid and waits until every queued reading has come out. It always waits on
	// the clock before it returns, so valid is never lowered and raised within one time step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// A bus reset with presence, then the first n_bytes bytes of the scratchpad. Fields
	// that the block should ignore carry random values.
	task automatic send_frame(input pad_t pad, input int unsigned n_bytes);
		int unsigned i;
		send_beat(KIND_BUS_RESET, 1'b1, 8'($urandom));
		for (i = 0; i < n_bytes; i++) begin
			send_beat(KIND_SCRATCH, 1'($urandom), pad[i]);
		end
	endtask

	// Writes the CRC byte of a scratchpad, or a corrupted one.
	function automatic pad_t seal_pad(input pad_t pad, input bit crc_ok);
		pad_t        p;
		logic [7:0]  c;
		int unsigned i;
		p = pad;
		c = '0;
		for (i = 0; i < 8; i++) begin
			c = sb.crc_next(c, p[i]);
		end
		p[8] = crc_ok ? c : c ^ 8'($urandom_range(1, 255));
		return p;
	endfunction

	// Random scratchpad. The temperature bytes now and then take their extreme values so
	// that the largest, the most negative and the all-ones readings turn up.
	function automatic pad_t random_pad(input bit crc_ok);
		pad_t        p;
		logic [7:0]  edge_vals [4];
		int unsigned i;
		edge_vals = '{8'h00, 8'hFF, 8'h7F, 8'h80};
		for (i = 0; i < 8; i++) begin
			p[i] = 8'($urandom);
		end
		if ($urandom_range(0, 6) == 0) begin
			p[0] = edge_vals[$urandom_range(0, 3)];
			p[1] = edge_vals[$urandom_range(0, 3)];
		end
		return seal_pad(p, crc_ok);
	endfunction

	initial begin : stimulus
		pad_t        pad;
		int unsigned pick;
		int unsigned n;
		int unsigned i;
		bit          left_open;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// A byte with no frame open must be dropped without a trace.
		send_beat(KIND_SCRATCH, 1'b1, 8'hFF);
		// A reset that nobody answers gives the no-device reading.
		send_beat(KIND_BUS_RESET, 1'b0, 8'hFF);
		// A frame cut short by a fresh reset is abandoned silently.
		send_frame('{8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 2);
		// The power-on scratchpad of the sensor: +85 degrees, 12-bit resolution and a
		// known CRC byte, which pins down the CRC independently of any computation here.
		send_frame('{8'h50, 8'h05, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10, 8'h1C}, 9);
		// Most negative temperature, 9-bit resolution, and a corrupted CRC byte:
		// a CRC error with zero data.
		pad = seal_pad('{8'h00, 8'h80, 8'h00, 8'h00, 8'h1F, 8'hFF, 8'h00, 8'h00, 8'h00},
			1'b0);
		send_frame(pad, 9);
		wait_drained();

		// Back pressure: the receiver stops for a long stretch while the sender keeps
		// offering no-device resets that each produce a reading, then whole frames, so the queue
		// fills and in_ready drops. No gaps on the sender side during this part.
		hold_req   = 1'b1;
		burst_left = 100;
		for (i = 0; i < 12; i++) begin
			send_beat(KIND_BUS_RESET, 1'b0, 8'($urandom));
		end
		for (i = 0; i < 3; i++) begin
			send_frame(random_pad(1'b1), 9);
		end
		wait_drained();

		// Random part. Most sequences are whole frames with random content, since only
		// they reach the temperature path; the rest are lone resets, frames cut short
		// by either kind of reset, and stray bytes between frames.
		left_open = 1'b0;
		while (beats_sent - ignored_beats < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(random_pad($urandom_range(0, 99) < 85), 9);
				left_open = 1'b0;
			end else if (pick < 78) begin
				send_beat(KIND_BUS_RESET, 1'b0, 8'($urandom));
				left_open = 1'b0;
			end else if (pick < 86) begin
				send_frame(random_pad(1'b1), $urandom_range(0, 8));
				left_open = 1'b1;
			end else if (pick < 92) begin
				send_frame(random_pad(1'b1), $urandom_range(0, 8));
				send_beat(KIND_BUS_RESET, 1'b0, 8'($urandom));
				left_open = 1'b0;
			end else if (!left_open) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					send_beat(KIND_SCRATCH, 1'($urandom), 8'($urandom));
				end
				ignored_beats += n;
			end else begin
				send_frame(random_pad(1'b1), 9);
				left_open = 1'b0;
			end
			// Now and then the sender sits still until the block has emptied.
			if ($urandom_range(0, 39) == 0) begin
				wait_drained();
			end
		end

		// Let everything drain, then watch a little longer for stray result beats.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input beats (%0d stray bytes); checked %0d good readings,",
			beats_sent, ignored_beats, sb.n_good);
		$display("%0d CRC errors, %0d no-device reports; input stalled %0d cycles, %0d hold-offs.",
			sb.n_crc_bad, sb.n_no_dev, in_stall_cycles, hold_count);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
